// ----- sv/psrx_pkg.sv -----
// Shared types and constants of the PS/2 receiver with scancode FIFO.
// Used by psrx_fifo and ps2_receiver_scancode_fifo; depends on nothing.
package psrx_pkg;

	// Item modes
	localparam logic [1:0] MODE_EDGE   = 2'd0;
	localparam logic [1:0] MODE_INJECT = 2'd1;
	localparam logic [1:0] MODE_POP    = 2'd2;

	// Scancode prefix bytes
	localparam logic [7:0] CODE_BREAK = 8'hF0;
	localparam logic [7:0] CODE_EXT0  = 8'hE0;
	localparam logic [7:0] CODE_EXT1  = 8'hE1;

	// Fixed field widths
	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 4;
	localparam int BYTES_W = 64;

	// Frame bit positions after the increment
	localparam logic [3:0] BP_START   = 4'd1;
	localparam logic [3:0] BP_DATA_LO = 4'd2;
	localparam logic [3:0] BP_DATA_HI = 4'd9;
	localparam logic [3:0] BP_PARITY  = 4'd10;

	// Per-cycle request to the byte FIFO
	typedef struct packed {
		logic               push;
		logic [BYTE_W-1:0]  push_data;
		logic               inject;
		logic [LEN_W-1:0]   inj_len;
		logic [BYTES_W-1:0] inj_data;
		logic [1:0]         pop_len;
	} psrx_fifo_ctl_t;

endpackage

// ----- sv/psrx_fifo.sv -----
// Compacting byte FIFO: entry 0 is always the oldest byte, pops shift down.
// Takes one push, a multi-byte inject or a pop of up to three bytes per cycle.
// Depends on psrx_pkg.
module psrx_fifo import psrx_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int CW    = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  psrx_fifo_ctl_t      ctl,
	output logic [CW-1:0]       count,
	output logic [CW-1:0]       count_next,
	output logic [BYTE_W-1:0]   head0,
	output logic [BYTE_W-1:0]   head1,
	output logic [BYTE_W-1:0]   head2
);

	localparam int SW = CW + 1;

	logic [BYTE_W-1:0] ent_q [DEPTH];
	logic [BYTE_W-1:0] ext [DEPTH+3];
	logic [CW-1:0]     count_q;
	logic [SW-1:0]     sum;

	// Pad the storage so that shifted reads stay in range
	always_comb begin
		for (int j = 0; j < DEPTH; j++) begin
			ext[j] = ent_q[j];
		end
		for (int j = DEPTH; j < DEPTH + 3; j++) begin
			ext[j] = '0;
		end
	end

	// Per-entry next value: shift on pop, load on push or inject, else hold
	for (genvar i = 0; i < DEPTH; i++) begin : g_ent
		logic [BYTE_W-1:0] ent_d;
		logic [CW-1:0]     off;

		assign off = CW'(i) - count_q;

		always_comb begin
			ent_d = ent_q[i];
			if (ctl.pop_len != 2'd0) begin
				case (ctl.pop_len)
					2'd1:    ent_d = ext[i+1];
					2'd2:    ent_d = ext[i+2];
					2'd3:    ent_d = ext[i+3];
					default: ent_d = ent_q[i];
				endcase
			end else if (ctl.push && CW'(i) == count_q) begin
				ent_d = ctl.push_data;
			end else if (ctl.inject && CW'(i) >= count_q
					&& SW'(off) < SW'(ctl.inj_len)) begin
				ent_d = ctl.inj_data[{off[2:0], 3'b000} +: BYTE_W];
			end
		end

		always_ff @(posedge clk) begin
			ent_q[i] <= ent_d;
		end
	end

	// Track fill level
	always_comb begin
		sum = SW'(count_q);
		if (ctl.push) begin
			sum = sum + SW'(1);
		end
		if (ctl.inject) begin
			sum = sum + SW'(ctl.inj_len);
		end
		sum = sum - SW'(ctl.pop_len);
	end

	assign count_next = sum[CW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	assign count = count_q;
	assign head0 = ent_q[0];
	assign head1 = ent_q[1];
	assign head2 = ent_q[2];

endmodule

// ----- sv/ps2_receiver_scancode_fifo.sv -----
// PS/2 keyboard receiver (odd parity) with a scancode byte FIFO, top level.
// Depends on psrx_pkg and psrx_fifo.
//
// Channel  Dir  Handshake            Payload
// in       in   in_valid / in_stall  mode, data_bit, inject_len, inject_bytes
// out      out  out_valid / out_stall accepted, code_len, code_first, code_second,
//                                    code_third, byte_stored, parity_error,
//                                    overflow_drop, fill_level
//
// One item per cycle sustained while out_stall is low; each item goes through
// an input register, and its result loads into the result register as it advances.
// Frame state, FIFO update and pop decode all resolve in the one stage between
// those two registers. Reset clears frame state, FIFO fill and both stages.
// A stall on the output holds the result register and, once the input
// register is also full, raises in_stall in the same cycle.
module ps2_receiver_scancode_fifo import psrx_pkg::*; #(
	parameter int DEPTH      = 16,
	parameter int MAX_INJECT = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   mode,
	input  logic                         data_bit,
	input  logic [LEN_W-1:0]             inject_len,
	input  logic [BYTES_W-1:0]           inject_bytes,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         accepted,
	output logic [1:0]                   code_len,
	output logic [BYTE_W-1:0]            code_first,
	output logic [BYTE_W-1:0]            code_second,
	output logic [BYTE_W-1:0]            code_third,
	output logic                         byte_stored,
	output logic                         parity_error,
	output logic                         overflow_drop,
	output logic [$clog2(DEPTH+1)-1:0]   fill_level
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = $clog2(DEPTH + MAX_INJECT + 1) + 1;

	// Input stage
	logic                 valid_s1;
	logic [1:0]           mode_s1;
	logic                 data_bit_s1;
	logic [LEN_W-1:0]     inject_len_s1;
	logic [BYTES_W-1:0]   inject_bytes_s1;

	// Frame state
	logic [3:0]        bp_q;
	logic [BYTE_W-1:0] shift_q;
	logic              par_acc_q;
	logic              par_bad_q;

	// Result register
	logic              out_valid_q;
	logic              accepted_q;
	logic [1:0]        code_len_q;
	logic [BYTE_W-1:0] code_first_q;
	logic [BYTE_W-1:0] code_second_q;
	logic [BYTE_W-1:0] code_third_q;
	logic              byte_stored_q;
	logic              parity_error_q;
	logic              overflow_drop_q;
	logic [CW-1:0]     fill_q;

	logic              advance;
	logic [3:0]        bp_inc;
	logic              in_data;
	logic              frame_done;
	logic              fifo_full;
	logic              len_ok;
	logic              cap_ok;
	logic              is_break;
	logic              is_ext;
	logic              second_break;
	logic [1:0]        need_len;
	logic              pop_ok;

	logic              do_edge;
	logic              do_inject;
	logic              do_pop;

	psrx_fifo_ctl_t    ctl;
	logic [CW-1:0]     count;
	logic [CW-1:0]     count_next;
	logic [BYTE_W-1:0] head0;
	logic [BYTE_W-1:0] head1;
	logic [BYTE_W-1:0] head2;

	// Move the stage forward unless the result register is held
	assign advance  = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;

	// Capture the input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			mode_s1         <= mode;
			data_bit_s1     <= data_bit;
			inject_len_s1   <= inject_len;
			inject_bytes_s1 <= inject_bytes;
		end
	end

	// Decode the mode of the item in the stage
	always_comb begin
		do_edge   = 1'b0;
		do_inject = 1'b0;
		do_pop    = 1'b0;
		unique case (mode_s1)
			MODE_EDGE:   do_edge   = advance;
			MODE_INJECT: do_inject = advance;
			MODE_POP:    do_pop    = advance;
			default:     ;
		endcase
	end

	// Frame position and completion
	assign bp_inc     = bp_q + 4'd1;
	assign in_data    = (bp_inc >= BP_DATA_LO) && (bp_inc <= BP_DATA_HI);
	assign frame_done = (bp_inc != BP_START) && !in_data && (bp_inc != BP_PARITY);
	assign fifo_full  = (count == CW'(DEPTH));

	// Inject admission
	assign len_ok = (inject_len_s1 != '0) && (SW'(inject_len_s1) <= SW'(MAX_INJECT));
	assign cap_ok = (SW'(count) + SW'(inject_len_s1)) < SW'(DEPTH);

	// Scancode length at the FIFO head
	assign is_break     = (head0 == CODE_BREAK);
	assign is_ext       = (head0 == CODE_EXT0) || (head0 == CODE_EXT1);
	assign second_break = (count > CW'(1)) && (head1 == CODE_BREAK);

	always_comb begin
		if (is_break) begin
			need_len = 2'd2;
		end else if (is_ext) begin
			need_len = second_break ? 2'd3 : 2'd2;
		end else begin
			need_len = 2'd1;
		end
	end

	assign pop_ok = (count != '0) && (count >= CW'(need_len));

	// Build the FIFO request
	always_comb begin
		ctl           = '0;
		ctl.push      = do_edge && frame_done && !par_bad_q && !fifo_full;
		ctl.push_data = shift_q;
		ctl.inject    = do_inject && len_ok && cap_ok;
		ctl.inj_len   = inject_len_s1;
		ctl.inj_data  = inject_bytes_s1;
		ctl.pop_len   = (do_pop && pop_ok) ? need_len : 2'd0;
	end

	psrx_fifo #(
		.DEPTH (DEPTH),
		.CW    (CW)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.count      (count),
		.count_next (count_next),
		.head0      (head0),
		.head1      (head1),
		.head2      (head2)
	);

	// Advance the frame on each clock edge item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bp_q      <= '0;
			shift_q   <= '0;
			par_acc_q <= 1'b0;
			par_bad_q <= 1'b0;
		end else if (do_edge) begin
			if (bp_inc == BP_START) begin
				bp_q      <= bp_inc;
				shift_q   <= '0;
				par_acc_q <= 1'b0;
				par_bad_q <= 1'b0;
			end else if (in_data) begin
				bp_q      <= bp_inc;
				par_acc_q <= par_acc_q ^ data_bit_s1;
				shift_q   <= {data_bit_s1, shift_q[BYTE_W-1:1]};
			end else if (bp_inc == BP_PARITY) begin
				bp_q <= bp_inc;
				if (par_acc_q == data_bit_s1) begin
					par_bad_q <= 1'b1;
				end
			end else begin
				bp_q <= '0;
			end
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the result fields
	always_ff @(posedge clk) begin
		if (advance) begin
			accepted_q      <= ctl.inject || (ctl.pop_len != 2'd0);
			code_len_q      <= ctl.pop_len;
			code_first_q    <= (ctl.pop_len != 2'd0) ? head0 : '0;
			code_second_q   <= (ctl.pop_len >= 2'd2) ? head1 : '0;
			code_third_q    <= (ctl.pop_len == 2'd3) ? head2 : '0;
			byte_stored_q   <= ctl.push;
			parity_error_q  <= do_edge && frame_done && par_bad_q;
			overflow_drop_q <= do_edge && frame_done && !par_bad_q && fifo_full;
			fill_q          <= count_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign accepted      = accepted_q;
	assign code_len      = code_len_q;
	assign code_first    = code_first_q;
	assign code_second   = code_second_q;
	assign code_third    = code_third_q;
	assign byte_stored   = byte_stored_q;
	assign parity_error  = parity_error_q;
	assign overflow_drop = overflow_drop_q;
	assign fill_level    = fill_q;

	// Checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CW'(DEPTH))
		else $error("FIFO fill above depth");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(count))
		else $error("FIFO fill changed without a stage advance");

	a_frame_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $onehot0({byte_stored_q, parity_error_q, overflow_drop_q}))
		else $error("more than one frame outcome flagged");

	a_code_acc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (code_len_q != 2'd0) |-> accepted_q && !byte_stored_q)
		else $error("scancode delivered without accept");

	a_fill_match: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> fill_q == count)
		else $error("reported fill differs from FIFO fill");

endmodule

// ----- verif/tb.sv -----
// Testbench of ps2_receiver_scancode_fifo: a short directed run, then random
// frames, injects and pops, each result checked against a scoreboard mirror.
// Depends on psrx_pkg and the RTL of the block.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import psrx_pkg::*;

	localparam int DEPTH          = 16;
	localparam int MAX_INJECT     = 8;
	localparam int FILL_W         = $clog2(DEPTH + 1);
	localparam int FRAME_BITS     = 11;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int PHASE_ITEMS    = 200;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic              accepted;
		logic [1:0]        code_len;
		logic [7:0]        first;
		logic [7:0]        second;
		logic [7:0]        third;
		logic              stored;
		logic              perr;
		logic              ovf;
		logic [FILL_W-1:0] fill;
	} scan_result_t;

	// Mirror of the frame counter and the byte FIFO, plus the results still due
	class scancode_scoreboard;
		bit [3:0]     bit_pos;
		bit [7:0]     shifter;
		bit           par_acc;
		bit           par_bad;
		bit [7:0]     held[$];
		scan_result_t due[$];
		int           errors;

		function int fill();
			return held.size();
		endfunction

		function int pending();
			return due.size();
		endfunction

		// Work out the result of one accepted transfer and queue it
		function void note_item(logic [1:0] md, logic db, logic [LEN_W-1:0] len,
				logic [BYTES_W-1:0] raw);
			scan_result_t r;
			int n;
			r = '0;
			case (md)
			MODE_EDGE: begin
				bit_pos++;
				if (bit_pos == BP_START) begin
					shifter = '0;
					par_acc = 1'b0;
					par_bad = 1'b0;
				end else if (bit_pos >= BP_DATA_LO && bit_pos <= BP_DATA_HI) begin
					par_acc ^= db;
					shifter = {db, shifter[7:1]};
				end else if (bit_pos == BP_PARITY) begin
					// odd parity: the bit must differ from the data ones parity
					if (par_acc == db)
						par_bad = 1'b1;
				end else begin
					if (par_bad)
						r.perr = 1'b1;
					else if (held.size() < DEPTH) begin
						held.push_back(shifter);
						r.stored = 1'b1;
					end else
						r.ovf = 1'b1;
					bit_pos = '0;
				end
			end
			MODE_INJECT: begin
				// never let an inject take the last entry
				if (len != 0 && len <= MAX_INJECT && held.size() + len < DEPTH) begin
					for (int i = 0; i < len; i++)
						held.push_back(raw[8*i +: 8]);
					r.accepted = 1'b1;
				end
			end
			MODE_POP: begin
				if (held.size() > 0) begin
					n = 1;
					if (held[0] == CODE_BREAK)
						n = 2;
					else if (held[0] == CODE_EXT0 || held[0] == CODE_EXT1)
						n = (held.size() > 1 && held[1] == CODE_BREAK) ? 3 : 2;
					// pop only a complete scancode
					if (held.size() >= n) begin
						r.accepted = 1'b1;
						r.code_len = 2'(n);
						r.first = held.pop_front();
						if (n > 1)
							r.second = held.pop_front();
						if (n > 2)
							r.third = held.pop_front();
					end
				end
			end
			default: ;
			endcase
			r.fill = FILL_W'(held.size());
			due.push_back(r);
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			end
		endfunction

		// Compare one result transfer with the oldest expectation
		function void check_result(scan_result_t got);
			scan_result_t want;
			if (due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %p", $time, got);
				return;
			end
			want = due.pop_front();
			compare_field("accepted", want.accepted, got.accepted);
			compare_field("code_len", want.code_len, got.code_len);
			compare_field("code_first", want.first, got.first);
			compare_field("code_second", want.second, got.second);
			compare_field("code_third", want.third, got.third);
			compare_field("byte_stored", want.stored, got.stored);
			compare_field("parity_error", want.perr, got.perr);
			compare_field("overflow_drop", want.ovf, got.ovf);
			compare_field("fill_level", want.fill, got.fill);
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         mode = MODE_EDGE;
	logic               data_bit = 1'b0;
	logic [LEN_W-1:0]   inject_len = '0;
	logic [BYTES_W-1:0] inject_bytes = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               accepted;
	logic [1:0]         code_len;
	logic [7:0]         code_first;
	logic [7:0]         code_second;
	logic [7:0]         code_third;
	logic               byte_stored;
	logic               parity_error;
	logic               overflow_drop;
	logic [FILL_W-1:0]  fill_level;

	scancode_scoreboard sb = new;
	scan_result_t       seen;
	int                 src_idle_pct = 15;
	int                 sink_stall_pct = 46;
	int                 edge_phase = 0;
	int                 items_sent = 0;
	int                 quiet_cycles = 0;
	bit                 in_take = 1'b0;
	bit                 out_take = 1'b0;

	ps2_receiver_scancode_fifo #(
		.DEPTH(DEPTH),
		.MAX_INJECT(MAX_INJECT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.data_bit(data_bit),
		.inject_len(inject_len),
		.inject_bytes(inject_bytes),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.accepted(accepted),
		.code_len(code_len),
		.code_first(code_first),
		.code_second(code_second),
		.code_third(code_third),
		.byte_stored(byte_stored),
		.parity_error(parity_error),
		.overflow_drop(overflow_drop),
		.fill_level(fill_level)
	);

	always #2 clk = ~clk;

	// Stall the result side at random
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < sink_stall_pct);
	end

	// Sample both handshakes mid-cycle, when every signal has settled
	always @(negedge clk) begin
		in_take = arst_n && in_valid && !in_stall;
		out_take = arst_n && out_valid && !out_stall;
		if (in_take)
			sb.note_item(mode, data_bit, inject_len, inject_bytes);
		if (out_take) begin
			seen.accepted = accepted;
			seen.code_len = code_len;
			seen.first = code_first;
			seen.second = code_second;
			seen.third = code_third;
			seen.stored = byte_stored;
			seen.perr = parity_error;
			seen.ovf = overflow_drop;
			seen.fill = fill_level;
			sb.check_result(seen);
		end
		// end the run if nothing moves for too long
		if (in_take || out_take || !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic logic [7:0] random_code_byte();
		case ($urandom_range(7))
		0: return CODE_BREAK;
		1: return CODE_EXT0;
		2: return CODE_EXT1;
		default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [BYTES_W-1:0] random_code_word();
		logic [BYTES_W-1:0] w;
		for (int i = 0; i < 8; i++)
			w[8*i +: 8] = random_code_byte();
		return w;
	endfunction

	function automatic logic [LEN_W-1:0] random_inject_len();
		if ($urandom_range(9) == 0)
			return LEN_W'($urandom_range(15));
		return LEN_W'($urandom_range(1, MAX_INJECT));
	endfunction

	// Present one item, wait for its transfer; call at a rising edge only
	task automatic drive_item(logic [1:0] md, logic db, logic [LEN_W-1:0] len,
			logic [BYTES_W-1:0] raw);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= md;
		data_bit <= db;
		inject_len <= len;
		inject_bytes <= raw;
		do @(posedge clk); while (!in_take);
		if (md != MODE_UNUSED)
			items_sent++;
		if (md == MODE_EDGE)
			edge_phase = (edge_phase + 1) % FRAME_BITS;
	endtask

	task automatic send_edge(logic db);
		drive_item(MODE_EDGE, db, LEN_W'($urandom), {$urandom, $urandom});
	endtask

	task automatic send_inject(logic [LEN_W-1:0] len, logic [BYTES_W-1:0] raw);
		drive_item(MODE_INJECT, 1'($urandom), len, raw);
	endtask

	task automatic send_pop();
		drive_item(MODE_POP, 1'($urandom), LEN_W'($urandom), {$urandom, $urandom});
	endtask

	task automatic send_unused();
		drive_item(MODE_UNUSED, 1'($urandom), LEN_W'($urandom), {$urandom, $urandom});
	endtask

	// Send one 11-bit frame, now and then mixing an inject or a pop into it
	task automatic send_frame(logic [7:0] data, bit good);
		logic [FRAME_BITS-1:0] bits;
		// realign to a frame boundary with stray edges
		while (edge_phase != 0)
			send_edge(1'($urandom));
		bits = {1'($urandom), good ? ~^data : ^data, data, 1'($urandom)};
		for (int i = 0; i < FRAME_BITS; i++) begin
			send_edge(bits[i]);
			if (i < FRAME_BITS - 1 && $urandom_range(24) == 0) begin
				if ($urandom_range(1))
					send_inject(random_inject_len(), random_code_word());
				else
					send_pop();
			end
		end
	endtask

	// Fill the FIFO by inject, then send two frames, so that the second is normally dropped
	task automatic flood_fifo();
		while (sb.fill() + MAX_INJECT < DEPTH)
			send_inject(LEN_W'(MAX_INJECT), random_code_word());
		if (sb.fill() < DEPTH - 1)
			send_inject(LEN_W'(DEPTH - 1 - sb.fill()), random_code_word());
		repeat (2) send_frame(random_code_byte(), 1'b1);
	endtask

	task automatic random_action();
		int pick;
		pick = $urandom_range(99);
		if (pick < 35)
			send_frame(random_code_byte(), $urandom_range(7) != 0);
		else if (pick < 53)
			send_inject(random_inject_len(), random_code_word());
		else if (pick < 78)
			send_pop();
		else if (pick < 83)
			repeat ($urandom_range(3, 12)) send_pop();
		else if (pick < 86)
			flood_fifo();
		else if (pick < 96)
			repeat ($urandom_range(1, FRAME_BITS - 1)) send_edge(1'($urandom));
		else
			send_unused();
	endtask

	// Hold the sender off until every queued result has come back
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty pop, unused mode, inject limits, each scancode shape
		send_pop();
		send_unused();
		send_inject(LEN_W'(0), '1);
		send_inject(LEN_W'(15), {$urandom, $urandom});
		send_inject(LEN_W'(3), {40'h0, 8'h1C, CODE_BREAK, CODE_EXT0});
		send_pop();
		send_inject(LEN_W'(2), {48'h0, 8'h1C, CODE_BREAK});
		send_pop();
		send_inject(LEN_W'(1), {56'h0, CODE_EXT1});
		send_pop();
		send_inject(LEN_W'(1), {56'h0, 8'h14});
		send_pop();
		send_inject(LEN_W'(MAX_INJECT), '1);
		send_inject(LEN_W'(MAX_INJECT), '0);
		send_inject(LEN_W'(MAX_INJECT - 1), '0);
		send_frame(8'h5A, 1'b1);
		send_pop();

		// Random: three idling patterns, drained between them
		for (int ph = 0; ph < 3; ph++) begin
			settle();
			src_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 46 : 0;
			sink_stall_pct = (ph == 0) ? 46 : (ph == 1) ? 15 : 0;
			items_sent = 0;
			while (items_sent < PHASE_ITEMS)
				random_action();
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/psrx_pkg.sv
sv/psrx_fifo.sv
sv/ps2_receiver_scancode_fifo.sv
verif/tb.sv
